// ===== hdl/bpr82_pkg.sv =====
// Package for the bit-plane rule-82 automaton.
// Holds the generation count, the rule byte, the stage state type and the rule function.
// No dependencies.
`default_nettype none

package bpr82_pkg;

  // Number of generations, one pipeline stage each
  localparam int GENERATIONS = 2;

  // Elementary rule 82, Wolfram indexing: new cell = RULE_BITS[{left, center, right}]
  localparam logic [7:0] RULE_BITS = 8'h52;

  // Window state of one stage
  typedef enum logic [1:0] {
    ST_EMPTY,   // no byte held
    ST_CENTER,  // center held, left is the zero border
    ST_BOTH,    // left and center held
    ST_TAIL     // last byte taken, closing byte still to send
  } stage_state_t;

  // One generation on all 8 bit planes
  function automatic logic [7:0] apply_rule(input logic [7:0] l, input logic [7:0] c,
                                            input logic [7:0] r);
    logic [7:0] res;
    logic [2:0] idx;
    res = '0;
    for (int b = 0; b < 8; b++) begin
      idx = {l[b], c[b], r[b]};
      res[b] = RULE_BITS[idx];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bpr82_if.sv =====
// Valid/ready channel interfaces for the bit-plane rule-82 automaton.
// Input frame channel, result channel and the internal stage link.
// No dependencies.
`default_nettype none

// Input frame bytes
interface bpr82_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;
  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

// Result bytes
interface bpr82_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       result_last;
  modport source (output valid, output result_byte, output result_last, input ready);
  modport sink   (input valid, input result_byte, input result_last, output ready);
endinterface

// Link between generation stages
interface bpr82_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_byte;
  logic       last;
  modport source (output valid, output cell_byte, output last, input ready);
  modport sink   (input valid, input cell_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/bpr82_stage.sv =====
// One generation stage: three-byte window, rule logic and an output register.
// Depends on bpr82_pkg and bpr82_byte_if.
`default_nettype none

module bpr82_stage (
  input  logic                clk,
  input  logic                rst,
  bpr82_byte_if.sink          up,
  bpr82_byte_if.source        dn
);
  import bpr82_pkg::*;

  stage_state_t state, state_next;
  logic [7:0]   left, left_next;
  logic [7:0]   center, center_next;

  logic         out_valid;
  logic [7:0]   out_byte;
  logic         out_last;

  logic         out_free;
  logic         up_take;
  logic         emit;
  logic [7:0]   emit_byte;
  logic         emit_last;

  // Output register can load when empty or being drained this cycle
  assign out_free = !out_valid || dn.ready;
  assign up.ready = (state != ST_TAIL) && out_free;
  assign up_take  = up.valid && up.ready;

  // Next window state
  always_comb begin
    state_next  = state;
    left_next   = left;
    center_next = center;
    unique case (state) inside
      ST_EMPTY: begin
        if (up_take && !up.last) begin
          left_next   = '0;
          center_next = up.cell_byte;
          state_next  = ST_CENTER;
        end
      end
      ST_CENTER, ST_BOTH: begin
        if (up_take) begin
          left_next   = center;
          center_next = up.cell_byte;
          state_next  = up.last ? ST_TAIL : ST_BOTH;
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          left_next   = '0;
          center_next = '0;
          state_next  = ST_EMPTY;
        end
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  // Emitted byte: one-byte frame, sliding window, or closing byte with zero border
  always_comb begin
    emit      = 1'b0;
    emit_byte = apply_rule(left, center, up.cell_byte);
    emit_last = 1'b0;
    unique case (state) inside
      ST_EMPTY: begin
        emit      = up_take && up.last;
        emit_byte = apply_rule('0, up.cell_byte, '0);
        emit_last = 1'b1;
      end
      ST_CENTER, ST_BOTH: begin
        emit = up_take;
      end
      ST_TAIL: begin
        emit      = out_free;
        emit_byte = apply_rule(left, center, '0);
        emit_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_EMPTY;
      left   <= '0;
      center <= '0;
    end else begin
      state  <= state_next;
      left   <= left_next;
      center <= center_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (dn.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
    end
  end

  assign dn.valid     = out_valid;
  assign dn.cell_byte = out_byte;
  assign dn.last      = out_last;

endmodule

`default_nettype wire

// ===== hdl/bitplane_rule82_automaton.sv =====
// Top level of the bit-plane rule-82 automaton: a chain of generation stages.
// Depends on bpr82_pkg, the channel interfaces in bpr82_if and bpr82_stage.
//
//   channel | direction | payload                  | request
//   feed    | in        | data_byte, frame_last    | one frame byte
//   result  | out       | result_byte, result_last | one result byte
//
// One byte per cycle is taken while the chain flows. A frame of two or more bytes sends
// each stage to ST_TAIL for the closing byte of its window, where it takes no byte from
// upstream; a one-byte frame costs nothing extra.
// A result byte can leave only after the byte GENERATIONS places further on is taken or
// its frame has closed; each stage sends the closing byte of its window from ST_TAIL.
// rst is synchronous and empties every window and output register.
// A stalled result backs up through each stage's output register to feed.ready.
`default_nettype none

module bitplane_rule82_automaton (
  input  logic        clk,
  input  logic        rst,
  bpr82_in_if.sink    feed,
  bpr82_out_if.source result
);
  import bpr82_pkg::*;

  bpr82_byte_if link [GENERATIONS+1] ();

  // Feed into the first stage
  assign link[0].valid     = feed.valid;
  assign link[0].cell_byte = feed.data_byte;
  assign link[0].last      = feed.frame_last;
  assign feed.ready        = link[0].ready;

  // One stage per generation
  for (genvar g = 0; g < GENERATIONS; g++) begin : g_stage
    bpr82_stage u_stage (
      .clk (clk),
      .rst (rst),
      .up  (link[g]),
      .dn  (link[g+1])
    );
  end

  // Last stage drives the result channel
  assign result.valid         = link[GENERATIONS].valid;
  assign result.result_byte   = link[GENERATIONS].cell_byte;
  assign result.result_last   = link[GENERATIONS].last;
  assign link[GENERATIONS].ready = result.ready;

endmodule

`default_nettype wire

// ===== hdl/bpr82_checker.sv =====
// Port-level checks for the bit-plane rule-82 automaton, bound to the top level.
// Depends on bitplane_rule82_automaton being compiled first.
`default_nettype none

module bpr82_checker (
  input logic       clk,
  input logic       rst,
  input logic       feed_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] result_byte,
  input logic       result_last
);

  // Reset empties the output register of the last stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // Reset leaves the first stage free to take a byte
  a_reset_ready: assert property (@(posedge clk) rst |=> feed_ready)
    else $error("feed not ready right after reset");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_byte) && $stable(result_last))
    else $error("result payload changed while stalled");

endmodule

bind bitplane_rule82_automaton bpr82_checker u_bpr82_checker (
  .clk          (clk),
  .rst          (rst),
  .feed_ready   (feed.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_byte  (result.result_byte),
  .result_last  (result.result_last)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for bitplane_rule82_automaton: directed frames, then random frames under
// sender and receiver idling, each result byte checked against a built-in rule-82 predictor.
// Depends on bpr82_pkg, the channel interfaces in bpr82_if and the RTL top level.
`default_nettype none

module tb;
  import bpr82_pkg::*;

  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 44;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 4 * GENERATIONS + 10;
  localparam int REPORT_MAX    = 10;
  localparam int DIR_ROWS      = 22;

  // Idle percentages per phase: none, sender, receiver, both
  localparam int SRC_IDLE  [PHASES] = '{0, 59, 0, 16};
  localparam int SNK_STALL [PHASES] = '{0, 0, 59, 16};

  typedef struct packed {
    logic [7:0] cells;
    logic       last;
  } cell_item_t;

  // One frame byte; typed rows carry their single result written out by hand
  typedef struct packed {
    logic [7:0] cells;
    logic       last;
    logic       typed;
    logic [7:0] typed_cells;
    logic       typed_last;
  } dir_row_t;

  // Isolated cells die under rule 82, so every one-byte frame gives 00 with last set.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1},  // one-byte frame right after reset
    '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},  // one-byte frame, all planes set
    '{8'h5A, 1'b1, 1'b1, 8'h00, 1'b1},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},  // two-byte frame, all ones
    '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0},  // three-byte frame, single bits
    '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h7E, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 8'h00, 1'b0},  // longer frame: both stages fill and shift
    '{8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hC3, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},  // all-zero frame
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},  // four-byte frame
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h08, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b1}   // one-byte frame after a long one
  };

  logic clk;
  logic rst;

  bpr82_in_if  feed ();
  bpr82_out_if result ();

  bitplane_rule82_automaton u_top (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .result (result)
  );

  // Hand-written expectation riding along with the current request
  logic       typed_pending;
  logic [7:0] typed_cells;
  logic       typed_last;

  int src_idle_pct;
  int snk_stall_pct;
  int fail_count = 0;
  int idle_cycles;

  // Predictor state: sliding window of each generation stage
  logic [7:0] win_left   [GENERATIONS];
  logic [7:0] win_center [GENERATIONS];
  int         win_fill   [GENERATIONS];

  cell_item_t expected_cells [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Rule 82: a cell lives if left is set and right clear, or only right is set
  function automatic logic [7:0] rule82_gen(input logic [7:0] l, input logic [7:0] c,
                                            input logic [7:0] r);
    return (l & ~r) | (~l & ~c & r);
  endfunction

  // Push one accepted frame byte through every generation and queue what leaves
  task automatic predict_generations(input logic [7:0] cells, input logic last,
                                     input logic typed, input logic [7:0] t_cells,
                                     input logic t_last);
    cell_item_t cur [$];
    cell_item_t nxt [$];
    cell_item_t it;
    cur.insert(cur.size(), cell_item_t'{cells, last});
    for (int s = 0; s < GENERATIONS; s++) begin
      nxt = {};
      foreach (cur[i]) begin
        it = cur[i];
        if (win_fill[s] == 0) begin
          if (it.last) begin
            nxt.insert(nxt.size(), cell_item_t'{rule82_gen(8'h00, it.cells, 8'h00), 1'b1});
          end else begin
            win_left[s]   = 8'h00;
            win_center[s] = it.cells;
            win_fill[s]   = 1;
          end
        end else begin
          nxt.insert(nxt.size(),
                     cell_item_t'{rule82_gen(win_left[s], win_center[s], it.cells), 1'b0});
          if (it.last) begin
            nxt.insert(nxt.size(),
                       cell_item_t'{rule82_gen(win_center[s], it.cells, 8'h00), 1'b1});
            win_left[s]   = 8'h00;
            win_center[s] = 8'h00;
            win_fill[s]   = 0;
          end else begin
            win_left[s]   = win_center[s];
            win_center[s] = it.cells;
            win_fill[s]   = 2;
          end
        end
      end
      cur = nxt;
    end
    if (typed) begin
      expected_cells.insert(expected_cells.size(), cell_item_t'{t_cells, t_last});
    end else begin
      foreach (cur[i]) expected_cells.insert(expected_cells.size(), cur[i]);
    end
  endtask

  // Compare one result byte with the oldest expectation
  task automatic check_result(input logic [7:0] cells, input logic last);
    cell_item_t want;
    if (expected_cells.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("unexpected result: byte %02h last %0b", cells, last);
    end else begin
      want = expected_cells.pop_front();
      if (cells !== want.cells || last !== want.last) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("result mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   want.cells, want.last, cells, last);
      end
    end
  endtask

  // Drive one frame byte, with random idle cycles first, and wait for its acceptance
  task automatic send_cells(input logic [7:0] cells, input logic last, input logic typed,
                            input logic [7:0] t_cells, input logic t_last);
    while ($urandom_range(99) < src_idle_pct) begin
      feed.valid <= 1'b0;
      @(posedge clk);
    end
    feed.valid      <= 1'b1;
    feed.data_byte  <= cells;
    feed.frame_last <= last;
    typed_pending   <= typed;
    typed_cells     <= t_cells;
    typed_last      <= t_last;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
  endtask

  // Result side: check, predict, stall at random, and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      idle_cycles  = 0;
      for (int s = 0; s < GENERATIONS; s++) begin
        win_left[s]   = 8'h00;
        win_center[s] = 8'h00;
        win_fill[s]   = 0;
      end
    end else begin
      if (result.valid && result.ready)
        check_result(result.result_byte, result.result_last);
      if (feed.valid && feed.ready)
        predict_generations(feed.data_byte, feed.frame_last, typed_pending, typed_cells,
                            typed_last);
      result.ready <= ($urandom_range(99) >= snk_stall_pct);
      if ((result.valid && result.ready) || (feed.valid && feed.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then random frames phase by phase
  initial begin
    int         frame_len;
    int         sent;
    int         pick;
    logic [7:0] cells;
    rst             <= 1'b1;
    feed.valid      <= 1'b0;
    feed.data_byte  <= 8'h00;
    feed.frame_last <= 1'b0;
    typed_pending   <= 1'b0;
    typed_cells     <= 8'h00;
    typed_last      <= 1'b0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_cells(DIRECTED[i].cells, DIRECTED[i].last, DIRECTED[i].typed,
                 DIRECTED[i].typed_cells, DIRECTED[i].typed_last);

    for (int ph = 0; ph < PHASES; ph++) begin
      // hold off until every result of the frames so far has come back
      feed.valid <= 1'b0;
      @(posedge clk);
      while (expected_cells.size() != 0) @(posedge clk);
      src_idle_pct  = SRC_IDLE[ph];
      snk_stall_pct = SNK_STALL[ph];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // mostly short frames, now and then a long one
        frame_len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int k = 0; k < frame_len; k++) begin
          pick = $urandom_range(9);
          if (pick == 0)      cells = 8'h00;
          else if (pick == 1) cells = 8'hFF;
          else                cells = 8'($urandom_range(255));
          send_cells(cells, k == frame_len - 1, 1'b0, 8'h00, 1'b0);
        end
        sent += frame_len;
      end
    end

    // Drain: every frame closed, so all expectations must arrive
    feed.valid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_cells.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
